// ===== rtl/msw_pkg.sv =====
// Shared types, constants and lookup tables for the month start weekday unit.
// Holds the microcode program and the control word format. No dependencies.
package msw_pkg;

	localparam int unsigned MAX_YEAR   = 9999;
	localparam int unsigned FIRST_YEAR = 1753;

	localparam int unsigned MONTH_W = 4;
	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned DAY_W   = 3;
	localparam int unsigned LEN_W   = 5;
	localparam int unsigned PC_W    = 2;

	// residues of the first year, for the running leap test
	localparam logic [1:0] FIRST_MOD4   = 2'(FIRST_YEAR % 4);
	localparam logic [6:0] FIRST_MOD100 = 7'(FIRST_YEAR % 100);
	localparam logic [8:0] FIRST_MOD400 = 9'(FIRST_YEAR % 400);

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_YEAR,
		OP_MONTH,
		OP_EMIT
	} op_t;

	typedef enum logic [1:0] {
		C_NEVER,
		C_NO_INPUT,
		C_YEAR_MORE,
		C_OUT_BUSY
	} cond_t;

	// jump to target when cond holds, else fall through to pc + 1
	typedef struct packed {
		op_t              op;
		cond_t            cond;
		logic [PC_W-1:0]  target;
	} uword_t;

	typedef struct packed {
		logic no_input;
		logic year_more;
		logic out_busy;
	} status_t;

	localparam logic [PC_W-1:0] PC_LOAD  = 2'd0;
	localparam logic [PC_W-1:0] PC_YEAR  = 2'd1;
	localparam logic [PC_W-1:0] PC_MONTH = 2'd2;
	localparam logic [PC_W-1:0] PC_EMIT  = 2'd3;

	// control store
	function automatic uword_t ucode(input logic [PC_W-1:0] pc);
		uword_t w;
		w = '{op: OP_LOAD, cond: C_NEVER, target: PC_LOAD};
		case (pc)
			PC_LOAD:  w = '{op: OP_LOAD,  cond: C_NO_INPUT,  target: PC_LOAD};
			PC_YEAR:  w = '{op: OP_YEAR,  cond: C_YEAR_MORE, target: PC_YEAR};
			PC_MONTH: w = '{op: OP_MONTH, cond: C_NEVER,     target: PC_LOAD};
			PC_EMIT:  w = '{op: OP_EMIT,  cond: C_OUT_BUSY,  target: PC_EMIT};
			default:  w = '{op: OP_LOAD,  cond: C_NEVER,     target: PC_LOAD};
		endcase
		return w;
	endfunction

	// days before the month in a common year, modulo 7
	function automatic logic [DAY_W-1:0] month_shift(input logic [MONTH_W-1:0] m);
		logic [DAY_W-1:0] r;
		r = '0;
		case (m)
			4'd1:    r = 3'd0;
			4'd2:    r = 3'd3;
			4'd3:    r = 3'd3;
			4'd4:    r = 3'd6;
			4'd5:    r = 3'd1;
			4'd6:    r = 3'd4;
			4'd7:    r = 3'd6;
			4'd8:    r = 3'd2;
			4'd9:    r = 3'd5;
			4'd10:   r = 3'd0;
			4'd11:   r = 3'd3;
			4'd12:   r = 3'd5;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

	// month length in a common year
	function automatic logic [LEN_W-1:0] month_len(input logic [MONTH_W-1:0] m);
		logic [LEN_W-1:0] r;
		r = '0;
		case (m)
			4'd2:                      r = 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
			4'd1, 4'd3, 4'd5, 4'd7,
			4'd8, 4'd10, 4'd12:        r = 5'd31;
			default:                   r = 5'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/msw_ctrl.sv =====
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on msw_pkg.
module msw_ctrl import msw_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  status_t status,
	output uword_t  uword
);

	logic [PC_W-1:0] pc_q;
	logic            take;

	assign uword = ucode(pc_q);

	always_comb begin
		case (uword.cond)
			C_NEVER:     take = 1'b0;
			C_NO_INPUT:  take = status.no_input;
			C_YEAR_MORE: take = status.year_more;
			C_OUT_BUSY:  take = status.out_busy;
			default:     take = 1'b0;
		endcase
	end

	// pc + 1 wraps from the emit step back to the load step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_LOAD;
		end else if (take) begin
			pc_q <= uword.target;
		end else begin
			pc_q <= pc_q + 1'b1;
		end
	end

endmodule

// ===== rtl/msw_dp.sv =====
// Datapath: input capture, year walk with running leap residues, month
// adjustment and the output register. Depends on msw_pkg.
module msw_dp import msw_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  uword_t             uword,
	output status_t            status,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [MONTH_W-1:0] month_number,
	input  logic [YEAR_W-1:0]  year_number,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [DAY_W-1:0]   weekday_offset,
	output logic [DAY_W-1:0]   first_column,
	output logic [LEN_W-1:0]   days_in_month,
	output logic               leap_year,
	output logic               bad_input
);

	logic [MONTH_W-1:0] month_q;
	logic [YEAR_W-1:0]  year_q;
	logic [YEAR_W-1:0]  cursor_q;
	logic [1:0]         mod4_q;
	logic [6:0]         mod100_q;
	logic [8:0]         mod400_q;
	logic [DAY_W-1:0]   acc_q;
	logic [LEN_W-1:0]   len_q;
	logic               leap_q;
	logic               bad_q;
	logic               out_valid_q;

	logic               cur_leap;
	logic               in_bad;
	logic               year_step;
	logic               month_step;
	logic               emit;
	logic [DAY_W:0]     year_sum;
	logic [DAY_W:0]     month_sum;
	logic               late_month;

	assign cur_leap = ((mod4_q == 2'd0) && (mod100_q != 7'd0)) || (mod400_q == 9'd0);

	assign in_bad = (month_number < 4'd1) || (month_number > 4'd12) ||
	                (year_number < YEAR_W'(FIRST_YEAR)) ||
	                (year_number > YEAR_W'(MAX_YEAR));

	assign status.no_input  = !in_valid;
	assign status.year_more = !bad_q && (cursor_q < year_q);
	assign status.out_busy  = out_valid_q && out_stall;

	assign in_stall   = (uword.op != OP_LOAD);
	assign year_step  = (uword.op == OP_YEAR) && status.year_more;
	assign month_step = (uword.op == OP_MONTH);
	assign emit       = (uword.op == OP_EMIT) && !status.out_busy;

	// 365 = 1 mod 7, 366 = 2 mod 7
	assign year_sum   = {1'b0, acc_q} + (cur_leap ? 4'd2 : 4'd1);
	assign late_month = cur_leap && (month_q > 4'd2);
	assign month_sum  = {1'b0, acc_q} + {1'b0, month_shift(month_q)} + {3'd0, late_month};

	always_ff @(posedge clk) begin
		if ((uword.op == OP_LOAD) && in_valid) begin
			month_q  <= month_number;
			year_q   <= year_number;
			bad_q    <= in_bad;
			cursor_q <= YEAR_W'(FIRST_YEAR);
			mod4_q   <= FIRST_MOD4;
			mod100_q <= FIRST_MOD100;
			mod400_q <= FIRST_MOD400;
			acc_q    <= '0;
		end else if (year_step) begin
			cursor_q <= cursor_q + 1'b1;
			mod4_q   <= mod4_q + 1'b1;
			mod100_q <= (mod100_q == 7'd99)  ? 7'd0 : mod100_q + 1'b1;
			mod400_q <= (mod400_q == 9'd399) ? 9'd0 : mod400_q + 1'b1;
			acc_q    <= (year_sum >= 4'd7) ? DAY_W'(year_sum - 4'd7) : DAY_W'(year_sum);
		end else if (month_step) begin
			acc_q    <= (month_sum >= 4'd7) ? DAY_W'(month_sum - 4'd7) : DAY_W'(month_sum);
			leap_q   <= cur_leap;
			len_q    <= (cur_leap && (month_q == 4'd2)) ? 5'd29 : month_len(month_q);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			bad_input      <= bad_q;
			weekday_offset <= bad_q ? '0 : acc_q;
			first_column   <= (bad_q || (acc_q == 3'd6)) ? '0 : acc_q + 1'b1;
			days_in_month  <= bad_q ? '0 : len_q;
			leap_year      <= bad_q ? 1'b0 : leap_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/month_start_weekday_calc_unit.sv =====
// Month start weekday unit, top level.
// Takes a month and a Gregorian year and returns the weekday of the first of
// that month, its Sunday-based column, the month length and a leap flag.
//
// Channels: the input item (month_number, year_number) is taken at a rising
// edge with in_valid high and in_stall low; the result item is delivered at
// an edge with out_valid high and out_stall low.
// Timing: one item at a time. out_valid rises once the accepted item has
// passed the year walk from 1753 up to year_number, the month step and the
// emit step; the next item can be taken at the load step that follows. The
// year walk sets how long an item takes: one year of the range is counted
// per cycle. Out-of-range items skip the walk and go on to the month and
// emit steps.
// Stalls: the result sits in an output register, so the next item is accepted
// while the previous result waits; the sequencer holds at its emit step only
// when a new result is ready and the old one has not been taken.
// Reset: arst_n clears the step counter and the output valid; the unit is
// ready for an item on the first cycle after reset.
// Dependencies: msw_pkg, msw_ctrl, msw_dp.
module month_start_weekday_calc_unit import msw_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [MONTH_W-1:0] month_number,
	input  logic [YEAR_W-1:0]  year_number,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [DAY_W-1:0]   weekday_offset,
	output logic [DAY_W-1:0]   first_column,
	output logic [LEN_W-1:0]   days_in_month,
	output logic               leap_year,
	output logic               bad_input
);

	uword_t  uword;
	status_t status;

	// sequencer: load, walk years, add months, emit
	msw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.uword  (uword)
	);

	// day count kept modulo 7 throughout
	msw_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.uword          (uword),
		.status         (status),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.month_number   (month_number),
		.year_number    (year_number),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.weekday_offset (weekday_offset),
		.first_column   (first_column),
		.days_in_month  (days_in_month),
		.leap_year      (leap_year),
		.bad_input      (bad_input)
	);

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for month_start_weekday_calc_unit.
// Drives month/year queries and checks each result against a calendar predictor.
// Depends on msw_pkg and the RTL of the unit only.
`timescale 1ns / 1ps

module testbench;
	import msw_pkg::*;

	// one expected or observed result item
	typedef struct {
		logic [DAY_W-1:0] weekday;
		logic [DAY_W-1:0] column;
		logic [LEN_W-1:0] length;
		logic             leap;
		logic             bad;
	} month_facts_t;

	// Scoreboard: predicts the first-of-month facts for each accepted query and
	// matches arriving results against them, oldest first.
	class weekday_scoreboard;
		month_facts_t awaited[$];
		int unsigned  errors;

		function new();
			errors = 0;
		endfunction

		static function bit is_leap_year(int unsigned y);
			return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		endfunction

		// leap years in 1..n
		static function int unsigned leaps_upto(int unsigned n);
			return n / 4 - n / 100 + n / 400;
		endfunction

		static function month_facts_t calendar_predict(int unsigned m, int unsigned y);
			int unsigned  elapsed[13];
			int unsigned  lengths[13];
			int unsigned  days;
			int unsigned  wd;
			month_facts_t f;
			elapsed = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
			lengths = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
			f = '{weekday: '0, column: '0, length: '0, leap: 1'b0, bad: 1'b1};
			if (m < 1 || m > 12 || y < FIRST_YEAR || y > MAX_YEAR)
				return f;
			f.bad  = 1'b0;
			f.leap = is_leap_year(y);
			days = 365 * (y - FIRST_YEAR)
			     + leaps_upto(y - 1) - leaps_upto(FIRST_YEAR - 1)
			     + elapsed[m];
			if (f.leap && m > 2)
				days += 1;
			wd        = days % 7;
			f.weekday = DAY_W'(wd);
			f.column  = DAY_W'((wd + 1) % 7);
			f.length  = LEN_W'((f.leap && m == 2) ? 29 : lengths[m]);
			return f;
		endfunction

		function void log_request(logic [MONTH_W-1:0] m, logic [YEAR_W-1:0] y);
			awaited.push_back(calendar_predict(m, y));
		endfunction

		function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
			if (exp_v != act_v) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d",
					$time, name, exp_v, act_v);
			end
		endfunction

		function void compare_result(month_facts_t act);
			month_facts_t exp_f;
			if (awaited.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual wd=%0d col=%0d len=%0d leap=%0d bad=%0d",
					$time, act.weekday, act.column, act.length, act.leap, act.bad);
				return;
			end
			exp_f = awaited.pop_front();
			compare_field("weekday_offset", exp_f.weekday, act.weekday);
			compare_field("first_column",   exp_f.column,  act.column);
			compare_field("days_in_month",  exp_f.length,  act.length);
			compare_field("leap_year",      exp_f.leap,    act.leap);
			compare_field("bad_input",      exp_f.bad,     act.bad);
		endfunction
	endclass

	// clock, reset and DUT-facing signals; every input known from time zero
	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               in_valid     = 1'b0;
	logic               in_stall;
	logic [MONTH_W-1:0] month_number = '0;
	logic [YEAR_W-1:0]  year_number  = '0;
	logic               out_valid;
	logic               out_stall    = 1'b0;
	logic [DAY_W-1:0]   weekday_offset;
	logic [DAY_W-1:0]   first_column;
	logic [LEN_W-1:0]   days_in_month;
	logic               leap_year;
	logic               bad_input;

	// when set, neither side idles nor stalls (the long steady stretch)
	bit calm = 1'b0;

	weekday_scoreboard sb = new();

	month_start_weekday_calc_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.month_number   (month_number),
		.year_number    (year_number),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.weekday_offset (weekday_offset),
		.first_column   (first_column),
		.days_in_month  (days_in_month),
		.leap_year      (leap_year),
		.bad_input      (bad_input)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Receiver back-pressure: a fresh decision every falling edge, about 37 %
	// stalled, none at all while calm is set.
	always @(negedge clk) begin
		out_stall = calm ? 1'b0 : ($urandom_range(99) < 37);
	end

	// Result monitor: a result item is taken at a rising edge with out_valid
	// high and out_stall low; values are read before the DUT's updates land.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.compare_result('{weekday: weekday_offset, column: first_column,
				length: days_in_month, leap: leap_year, bad: bad_input});
	end

	// Offers one query. Entered and left at a falling edge. May first idle with
	// valid low; otherwise valid stays high straight from the previous item.
	// Payload holds steady until the item is accepted.
	task automatic send_query(input logic [MONTH_W-1:0] m, input logic [YEAR_W-1:0] y);
		if (!calm && $urandom_range(99) < 37) begin
			in_valid = 1'b0;
			repeat ($urandom_range(8, 1)) @(negedge clk);
		end
		in_valid     = 1'b1;
		month_number = m;
		year_number  = y;
		do @(posedge clk); while (in_stall);
		sb.log_request(m, y);
		@(negedge clk);
	endtask

	// Holds the sender off until every outstanding result has come back.
	task automatic drain_results();
		in_valid = 1'b0;
		while (sb.awaited.size() != 0) @(negedge clk);
	endtask

	// Random query mix. Most years sit close to 1753 because the unit walks
	// one year per cycle; only a few span the whole range.
	task automatic send_random_query();
		int unsigned pick;
		int unsigned m;
		int unsigned y;
		pick = $urandom_range(99);
		m    = $urandom_range(12, 1);
		if (pick < 60) begin
			y = $urandom_range(2300, FIRST_YEAR);
		end else if (pick < 68) begin
			y = $urandom_range(MAX_YEAR, FIRST_YEAR);
		end else if (pick < 78) begin
			// century and quad years around February, where the leap rule bites
			m = $urandom_range(3, 2);
			y = (pick & 1) ? 100 * $urandom_range(24, 18) : 4 * $urandom_range(600, 439);
		end else if (pick < 90) begin
			// month out of range: the year can be anything, no walk happens
			m = ($urandom_range(1)) ? 0 : $urandom_range(15, 13);
			y = $urandom_range(16383, 0);
		end else begin
			y = ($urandom_range(1)) ? $urandom_range(FIRST_YEAR - 1, 0)
			                        : $urandom_range(16383, MAX_YEAR + 1);
		end
		send_query(MONTH_W'(m), YEAR_W'(y));
	endtask

	initial begin
		// hold reset, then release it away from the rising edge
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: range edges, each month, leap rule cases, errors
		send_query(4'd1,  14'd1753);   // epoch, a Monday
		send_query(4'd2,  14'd1753);
		send_query(4'd2,  14'd1756);   // plain leap year
		send_query(4'd3,  14'd1756);
		send_query(4'd2,  14'd1800);   // century, not leap
		send_query(4'd3,  14'd1800);
		send_query(4'd2,  14'd2000);   // four-hundredth year, leap
		send_query(4'd3,  14'd2000);
		send_query(4'd4,  14'd2024);
		send_query(4'd5,  14'd2024);
		send_query(4'd6,  14'd2023);
		send_query(4'd7,  14'd1999);
		send_query(4'd8,  14'd1900);
		send_query(4'd9,  14'd1901);
		send_query(4'd10, 14'd1776);
		send_query(4'd11, 14'd1853);
		send_query(4'd12, 14'd1952);
		send_query(4'd12, 14'd9999);   // last accepted year, longest walk
		send_query(4'd0,  14'd2000);   // month below range
		send_query(4'd13, 14'd2000);   // month above range
		send_query(4'd15, 14'd1753);
		send_query(4'd1,  14'd1752);   // year just below range
		send_query(4'd1,  14'd10000);  // year just above range
		send_query(4'd0,  14'd0);      // both out of range
		send_query(4'd14, 14'd16383);
		drain_results();

		// random part with a steady stretch in the middle and a full drain
		for (int i = 0; i < 100; i++) begin
			calm = (i >= 35 && i < 60);
			if (i == 70)
				drain_results();
			send_random_query();
		end
		calm     = 1'b0;
		in_valid = 1'b0;

		// wait out anything still in flight, then allow one worst-case walk
		while (sb.awaited.size() != 0) @(negedge clk);
		repeat (8300) @(negedge clk);

		if (sb.errors == 0 && sb.awaited.size() == 0)
			$display("month_start_weekday_calc_unit regression: pass");
		else
			$display("month_start_weekday_calc_unit regression: fail");
		$finish;
	end

	// Watchdog: about 125 items, each at the worst walk, plus idling is near
	// 11 ms; this leaves several times that.
	initial begin
		#(64'd50_000_000);
		$display("month_start_weekday_calc_unit regression: fail");
		$finish;
	end

endmodule
